// File: design/arqrw_pkg.sv
// Shared types and constants for the ARQ receive reorder window.
// Used by arqrw_ctrl, arqrw_dpath and arq_receive_reorder_window.
package arqrw_pkg;

    localparam int SEQ_W     = 32;
    localparam int RING_LEN_W = 6;
    localparam int HOR_W     = 5;
    localparam int COUNT_W   = 5;
    localparam int MAP_W     = 16;
    localparam int STATUS_W  = 2;

    // input kind carried on tuser
    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_READ = 1'b1;

    // configuration register indexes
    localparam logic CFG_RING_LENGTH = 1'b0;
    localparam logic CFG_HOR_SPAN    = 1'b1;

    localparam logic [RING_LEN_W-1:0] RING_LEN_RESET = 6'd32;
    localparam logic [HOR_W-1:0]      HORIZON_RESET  = 5'd4;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE   = 2'd0,
        ST_WINDOW = 2'd1,
        ST_EMPTY  = 2'd2
    } t_status;

    // controller -> datapath
    typedef struct packed {
        logic accept;   // latch the input beat, load working indexes
        logic norm;     // reduce working indexes toward the ring length
        logic decide;   // window / empty check, issue slot read
        logic commit;   // write or pop the slot
        logic advance;  // move head one slot
        logic finish;   // load the output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic reduced;
        logic reject;
        logic adv_stop;
        logic out_free;
    } t_stat;

endpackage

// File: design/arqrw_ctrl.sv
// Sequencing state machine for the ARQ receive reorder window.
// Depends on arqrw_pkg for the command and status structs.
module arqrw_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  arqrw_pkg::t_stat i_stat,
    output arqrw_pkg::t_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_NORM,
        S_COMMIT,
        S_ADV
    } t_state;

    t_state r_state, n_state;
    logic   r_ready, n_ready;

    always_comb begin
        n_state = r_state;
        n_ready = r_ready;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && r_ready) begin
                    o_cmd.accept = 1'b1;
                    n_ready      = 1'b0;
                    n_state      = S_NORM;
                end
            end
            S_NORM: begin
                if (i_stat.reduced) begin
                    o_cmd.decide = 1'b1;
                    n_state      = i_stat.reject ? S_ADV : S_COMMIT;
                end else begin
                    o_cmd.norm = 1'b1;
                end
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = S_ADV;
            end
            S_ADV: begin
                if (!i_stat.adv_stop) begin
                    o_cmd.advance = 1'b1;
                end else if (i_stat.out_free) begin
                    // load the result once the output is free; hold here while the previous result is still waiting
                    o_cmd.finish = 1'b1;
                    n_ready      = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_ready = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ready <= 1'b1;
        end else begin
            r_state <= n_state;
            r_ready <= n_ready;
        end
    end

    assign o_in_ready = r_ready;

`ifndef SYNTH
    a_ready_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ready |-> (r_state == S_IDLE))
        else $error("ready raised outside idle");

    a_finish_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> (i_stat.out_free && i_stat.adv_stop))
        else $error("result loaded while output busy or head still moving");

    a_reject_skips_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.decide && i_stat.reject) |=> (r_state == S_ADV))
        else $error("rejected beat went on to commit");
`endif

endmodule

// File: design/arqrw_dpath.sv
// Datapath of the ARQ receive reorder window: config, ring indexes,
// fill bits, slot memory, head advance and the output register. Uses arqrw_pkg.
module arqrw_dpath #(
    parameter int RING_DEPTH  = 32,
    parameter int HANDLE_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic                               i_cfg_index,
    input  logic [arqrw_pkg::RING_LEN_W-1:0]   i_cfg_wdata,
    input  arqrw_pkg::t_cmd                    i_cmd,
    output arqrw_pkg::t_stat                   o_stat,
    input  logic                               i_action,
    input  logic [arqrw_pkg::SEQ_W-1:0]        i_rx_sequence,
    input  logic [HANDLE_BITS-1:0]             i_payload_handle,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [arqrw_pkg::STATUS_W-1:0]     o_status,
    output logic [HANDLE_BITS-1:0]             o_out_handle,
    output logic                               o_out_handle_valid,
    output logic [arqrw_pkg::SEQ_W-1:0]        o_out_sequence,
    output logic [arqrw_pkg::COUNT_W-1:0]      o_readable_count,
    output logic [arqrw_pkg::MAP_W-1:0]        o_horizon_bitmap
);

    localparam int IDX_W = $clog2(RING_DEPTH);
    localparam int LEN_W = $clog2(RING_DEPTH + 1);
    localparam int SUM_W = LEN_W + 1;
    localparam int RL_W  = arqrw_pkg::RING_LEN_W;
    localparam int HOR_W = arqrw_pkg::HOR_W;
    localparam int SEQ_W = arqrw_pkg::SEQ_W;
    localparam int MAP_W = arqrw_pkg::MAP_W;
    localparam int CL_W  = (LEN_W > RL_W) ? LEN_W : RL_W;
    localparam int HC_W  = (LEN_W > HOR_W) ? LEN_W : HOR_W;

    // configuration
    logic [RL_W-1:0]  r_ring_length;
    logic [HOR_W-1:0] r_hor_span;

    // ring state
    logic [IDX_W-1:0]      r_head, r_tail;
    logic [SEQ_W-1:0]      r_head_seq;
    logic [RING_DEPTH-1:0] r_filled;

    logic [HANDLE_BITS-1:0] mem_handle [RING_DEPTH];
    logic [SEQ_W-1:0]       mem_seq    [RING_DEPTH];
    logic [HANDLE_BITS-1:0] r_rd_handle;
    logic [SEQ_W-1:0]       r_rd_seq;

    // per-item working registers
    logic                   r_action;
    logic [SEQ_W-1:0]       r_seq;
    logic [HANDLE_BITS-1:0] r_handle;
    logic [IDX_W-1:0]       r_work_head, r_work_tail;
    logic [LEN_W-1:0]       r_len;
    logic [HOR_W-1:0]       r_hor;
    logic [LEN_W-1:0]       r_steps;
    logic                   r_err;
    logic [IDX_W-1:0]       r_slot;
    logic                   r_was_filled;
    arqrw_pkg::t_status     r_res_status;
    logic [HANDLE_BITS-1:0] r_res_handle;
    logic                   r_res_valid;
    logic [SEQ_W-1:0]       r_res_seq;

    // output register
    logic                              r_out_valid;
    arqrw_pkg::t_status                r_out_status;
    logic [HANDLE_BITS-1:0]            r_out_handle;
    logic                              r_out_handle_valid;
    logic [SEQ_W-1:0]                  r_out_seq;
    logic [arqrw_pkg::COUNT_W-1:0]     r_out_count;
    logic [MAP_W-1:0]                  r_out_map;

    logic [LEN_W-1:0] eff_len;
    logic [HOR_W-1:0] eff_hor;
    logic [LEN_W-1:0] head_ext, tail_ext;
    logic [SEQ_W-1:0] seq_gap;
    logic             win_miss, empty, reject;
    logic [SUM_W-1:0] slot_sum, slot_red;
    logic [IDX_W-1:0] slot_idx, rd_addr;
    logic [SUM_W-1:0] guard_sum, guard_red;
    logic             guard_hit, adv_stop;
    logic [LEN_W-1:0] head_inc, tail_inc;
    logic [IDX_W-1:0] head_next, tail_next;
    logic [LEN_W-1:0] count;
    logic [MAP_W-1:0] bitmap;
    logic             out_free;

    // clamp the ring length and the horizon
    always_comb begin
        logic [CL_W-1:0] rl_ext;
        logic [HC_W-1:0] hw_ext, lim_ext, hor_c;
        rl_ext = CL_W'(r_ring_length);
        if (rl_ext < CL_W'(3)) begin
            eff_len = LEN_W'(3);
        end else if (rl_ext > CL_W'(RING_DEPTH)) begin
            eff_len = LEN_W'(RING_DEPTH);
        end else begin
            eff_len = LEN_W'(rl_ext);
        end
        hw_ext  = HC_W'(r_hor_span);
        lim_ext = HC_W'(eff_len - LEN_W'(3));
        hor_c   = (hw_ext > lim_ext) ? lim_ext : hw_ext;
        if (hor_c > HC_W'(MAP_W)) begin
            hor_c = HC_W'(MAP_W);
        end
        eff_hor = HOR_W'(hor_c);
    end

    assign head_ext = LEN_W'(r_work_head);
    assign tail_ext = LEN_W'(r_work_tail);

    // window check and target slot; distance stays within the horizon when accepted
    assign seq_gap  = r_seq - r_head_seq;
    assign win_miss = seq_gap > SEQ_W'(r_hor);
    assign empty    = (r_work_head == r_work_tail);
    assign reject   = (r_action == arqrw_pkg::ACT_READ) ? empty : win_miss;
    assign slot_sum = SUM_W'(r_work_head) + SUM_W'(seq_gap[HOR_W-1:0]);
    assign slot_red = (slot_sum >= SUM_W'(r_len)) ? slot_sum - SUM_W'(r_len) : slot_sum;
    assign slot_idx = slot_red[IDX_W-1:0];
    assign rd_addr  = (r_action == arqrw_pkg::ACT_READ) ? r_work_tail : slot_idx;

    // head stops at an unfilled slot, on a reject, after a full lap, or a horizon plus one slot short of the tail
    assign guard_sum = SUM_W'(r_work_head) + SUM_W'(r_hor) + SUM_W'(1);
    assign guard_red = (guard_sum >= SUM_W'(r_len)) ? guard_sum - SUM_W'(r_len) : guard_sum;
    assign guard_hit = (guard_red == SUM_W'(r_work_tail));
    assign adv_stop  = r_err || !r_filled[r_work_head] || guard_hit || (r_steps == r_len);

    assign head_inc  = head_ext + LEN_W'(1);
    assign head_next = (head_inc == r_len) ? '0 : head_inc[IDX_W-1:0];
    assign tail_inc  = tail_ext + LEN_W'(1);
    assign tail_next = (tail_inc == r_len) ? '0 : tail_inc[IDX_W-1:0];

    assign count = (head_ext >= tail_ext) ? head_ext - tail_ext : head_ext + r_len - tail_ext;

    always_comb begin
        logic [SUM_W-1:0] lane, lane_red;
        bitmap = '0;
        for (int i = 0; i < MAP_W; i++) begin
            lane     = SUM_W'(r_work_head) + SUM_W'(i + 1);
            lane_red = (lane >= SUM_W'(r_len)) ? lane - SUM_W'(r_len) : lane;
            bitmap[i] = (i < int'(r_hor)) && r_filled[lane_red[IDX_W-1:0]];
        end
    end

    assign out_free = !r_out_valid || i_out_ready;

    assign o_stat.reduced  = (head_ext < r_len) && (tail_ext < r_len);
    assign o_stat.reject   = reject;
    assign o_stat.adv_stop = adv_stop;
    assign o_stat.out_free = out_free;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_length   <= arqrw_pkg::RING_LEN_RESET;
            r_hor_span      <= arqrw_pkg::HORIZON_RESET;
            r_head          <= '0;
            r_tail          <= '0;
            r_head_seq      <= '0;
            r_filled        <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    arqrw_pkg::CFG_RING_LENGTH: r_ring_length <= i_cfg_wdata;
                    arqrw_pkg::CFG_HOR_SPAN:    r_hor_span    <= i_cfg_wdata[HOR_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.commit) begin
                if (r_action == arqrw_pkg::ACT_READ) begin
                    r_filled[r_work_tail] <= 1'b0;
                    r_tail                <= tail_next;
                end else begin
                    r_filled[r_slot] <= 1'b1;
                end
            end
            if (i_cmd.advance) begin
                r_head     <= head_next;
                r_head_seq <= r_head_seq + SEQ_W'(1);
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // slot memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && r_action == arqrw_pkg::ACT_PUSH) begin
            mem_handle[r_slot] <= r_handle;
            mem_seq[r_slot]    <= r_seq;
        end
        r_rd_handle <= mem_handle[rd_addr];
        r_rd_seq    <= mem_seq[rd_addr];
    end

    // working and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_action    <= i_action;
            r_seq       <= i_rx_sequence;
            r_handle    <= i_payload_handle;
            r_work_head <= r_head;
            r_work_tail <= r_tail;
            r_len       <= eff_len;
            r_hor       <= eff_hor;
            r_steps     <= '0;
        end
        if (i_cmd.norm) begin
            if (head_ext >= r_len) begin
                r_work_head <= IDX_W'(head_ext - r_len);
            end
            if (tail_ext >= r_len) begin
                r_work_tail <= IDX_W'(tail_ext - r_len);
            end
        end
        if (i_cmd.decide) begin
            r_err        <= reject;
            r_slot       <= slot_idx;
            r_was_filled <= r_filled[slot_idx];
            r_res_handle <= '0;
            r_res_valid  <= 1'b0;
            r_res_seq    <= '0;
            if (r_action == arqrw_pkg::ACT_READ) begin
                r_res_status <= empty ? arqrw_pkg::ST_EMPTY : arqrw_pkg::ST_DONE;
            end else begin
                r_res_status <= win_miss ? arqrw_pkg::ST_WINDOW : arqrw_pkg::ST_DONE;
            end
        end
        if (i_cmd.commit) begin
            if (r_action == arqrw_pkg::ACT_READ) begin
                r_res_handle <= r_rd_handle;
                r_res_valid  <= 1'b1;
                r_res_seq    <= r_rd_seq;
                r_work_tail  <= tail_next;
            end else if (r_was_filled) begin
                // report the displaced handle
                r_res_handle <= r_rd_handle;
                r_res_valid  <= 1'b1;
            end
        end
        if (i_cmd.advance) begin
            r_work_head <= head_next;
            r_steps     <= r_steps + LEN_W'(1);
        end
        if (i_cmd.finish) begin
            r_out_status       <= r_res_status;
            r_out_handle       <= r_res_handle;
            r_out_handle_valid <= r_res_valid;
            r_out_seq          <= r_res_seq;
            r_out_count        <= arqrw_pkg::COUNT_W'(count);
            r_out_map          <= bitmap;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_status           = r_out_status;
    assign o_out_handle       = r_out_handle;
    assign o_out_handle_valid = r_out_handle_valid;
    assign o_out_sequence     = r_out_seq;
    assign o_readable_count   = r_out_count;
    assign o_horizon_bitmap   = r_out_map;

`ifndef SYNTH
    a_no_advance_on_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.advance |-> !r_err)
        else $error("head moved on a rejected beat");

    a_decide_on_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.decide |-> ((head_ext < r_len) && (tail_ext < r_len)))
        else $error("window check on unreduced indexes");

    a_pop_clears_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && r_action == arqrw_pkg::ACT_READ) |=> !r_filled[$past(r_work_tail)])
        else $error("popped slot still marked filled");
`endif

endmodule

// File: design/arq_receive_reorder_window.sv
// Selective-repeat ARQ receive window: top level with stream ports and config port.
// Steps: accept, index reduction (only if ring_length shrank), a window check, a slot-memory
// write or pop (skipped on a rejected beat), then head advance over the slots skipped and the
// result load. The result load, and so the next beat, waits while the previous result is
// still unread.
// Reset (sync, i_rst_n low): ring empty, indexes zero, ring_length 32, horizon 4, memory kept.
module arq_receive_reorder_window #(
    parameter int RING_DEPTH  = 32,
    parameter int HANDLE_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_index,
    input  logic [arqrw_pkg::RING_LEN_W-1:0]  i_cfg_wdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // rx_sequence[31:0], payload_handle, zero fill
    input  logic [((arqrw_pkg::SEQ_W + HANDLE_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // action
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // out_handle, out_sequence, readable_count, horizon_bitmap, zero fill
    output logic [((HANDLE_BITS + arqrw_pkg::SEQ_W + arqrw_pkg::COUNT_W
                    + arqrw_pkg::MAP_W + 7) / 8) * 8 - 1:0] m_axis_tdata,
    // status[1:0], out_handle_valid
    output logic [arqrw_pkg::STATUS_W:0]      m_axis_tuser
);

    localparam int OUT_W = ((HANDLE_BITS + arqrw_pkg::SEQ_W + arqrw_pkg::COUNT_W
                             + arqrw_pkg::MAP_W + 7) / 8) * 8;

    arqrw_pkg::t_cmd  cmd;
    arqrw_pkg::t_stat stat;

    logic [arqrw_pkg::STATUS_W-1:0] status;
    logic [HANDLE_BITS-1:0]         out_handle;
    logic                           out_handle_valid;
    logic [arqrw_pkg::SEQ_W-1:0]    out_sequence;
    logic [arqrw_pkg::COUNT_W-1:0]  readable_count;
    logic [arqrw_pkg::MAP_W-1:0]    horizon_bitmap;

    arqrw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    arqrw_dpath #(
        .RING_DEPTH  (RING_DEPTH),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_dpath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_cmd              (cmd),
        .o_stat             (stat),
        .i_action           (s_axis_tuser),
        .i_rx_sequence      (s_axis_tdata[arqrw_pkg::SEQ_W-1:0]),
        .i_payload_handle   (s_axis_tdata[arqrw_pkg::SEQ_W +: HANDLE_BITS]),
        .o_out_valid        (m_axis_tvalid),
        .i_out_ready        (m_axis_tready),
        .o_status           (status),
        .o_out_handle       (out_handle),
        .o_out_handle_valid (out_handle_valid),
        .o_out_sequence     (out_sequence),
        .o_readable_count   (readable_count),
        .o_horizon_bitmap   (horizon_bitmap)
    );

    assign m_axis_tdata = OUT_W'({horizon_bitmap, readable_count, out_sequence, out_handle});
    assign m_axis_tuser = {out_handle_valid, status};

endmodule
